// ----- hdl/rsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg - rectangle sum / point update shared definitions
// Grid geometry, field widths, and the control/status bundles passed
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package rsp_pkg;

	localparam int GRID_SIZE = 64;                  // power of two
	localparam int CW        = $clog2(GRID_SIZE);   // coordinate width
	localparam int IDX_W     = CW + 2;              // 1-based index, holds up to 2*GRID_SIZE
	localparam int ADDR_W    = 2 * CW;              // cell address {row, col}
	localparam int WEIGHT_W  = 16;
	localparam int SUM_W     = 32;

	localparam logic [IDX_W-1:0] GRID_IDX = IDX_W'(GRID_SIZE);

	// kind field codes
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// corner sequence of a query: bit 0 picks the low x edge, bit 1 the low y edge
	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_LAST  = 2'd3;

	typedef logic [CW-1:0]       coord_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// sequencer -> datapath
	typedef struct packed {
		logic       clr_en;    // write zero at the sweep address
		logic       load;      // capture a new transaction
		logic       start;     // set index registers for the add or current corner
		logic       advance;   // step to the next tree cell
		logic       add_wr;    // write back read data plus weight
		logic       rd_en;     // the read issued this cycle is accumulated
		logic       res_load;  // move the sum into the result register
		logic [1:0] corner;
	} dp_cmd_t;

	// datapath -> sequencer
	typedef struct packed {
		logic clr_last;  // sweep at the final address
		logic is_query;
		logic empty;     // query rectangle has no cells
		logic cell_ok;   // index pair addresses a tree cell
	} dp_sts_t;

endpackage

// ----- hdl/rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_if - valid/ready channels of the rectangle sum block
// Item channel (add or query) and result channel (one sum per query).
// ----------------------------------------------------------------------------
interface rsp_item_if;
	import rsp_pkg::*;

	logic    valid;
	logic    ready;
	logic    kind;
	coord_t  x_low;
	coord_t  y_low;
	coord_t  x_high;
	coord_t  y_high;
	weight_t weight;

	modport source (output valid, kind, x_low, y_low, x_high, y_high, weight, input ready);
	modport sink   (input valid, kind, x_low, y_low, x_high, y_high, weight, output ready);
endinterface

interface rsp_result_if;
	import rsp_pkg::*;

	logic valid;
	logic ready;
	sum_t range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

// ----- hdl/rsp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_datapath - Fenwick store, index walkers and accumulator
// Holds the tree memory, the row/column index registers that walk the
// tree, the signed corner accumulator and the result register.
// ----------------------------------------------------------------------------
module rsp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rsp_pkg::dp_cmd_t cmd,
	output rsp_pkg::dp_sts_t sts,
	input  logic             in_kind,
	input  rsp_pkg::coord_t  in_x_low,
	input  rsp_pkg::coord_t  in_y_low,
	input  rsp_pkg::coord_t  in_x_high,
	input  rsp_pkg::coord_t  in_y_high,
	input  rsp_pkg::weight_t in_weight,
	output rsp_pkg::sum_t    range_sum
);
	import rsp_pkg::*;

	function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
		return v & (~v + IDX_W'(1));
	endfunction

	// add walks upward to GRID_SIZE, query walks down to zero
	function automatic logic idx_ok(input logic [IDX_W-1:0] v, input logic up);
		return up ? (v != '0 && v <= GRID_IDX) : (v != '0);
	endfunction

	logic             kind_q;
	coord_t           xl_q, yl_q, xh_q, yh_q;
	weight_t          weight_q;
	logic [IDX_W-1:0] i_q, j_q, jb_q;
	logic [ADDR_W-1:0] clr_addr_q;
	sum_t             acc_q, res_q, mem_q;
	logic             rd_vld_s1, sub_s1;

	sum_t              mem [GRID_SIZE*GRID_SIZE];
	logic              is_add;
	logic [IDX_W-1:0]  si, sj, i_nx, j_nx;
	logic [CW-1:0]     row, col;
	logic [ADDR_W-1:0] cell_addr, wr_addr;
	sum_t              wr_data;
	logic              wr_en;

	assign is_add = (kind_q == KIND_ADD);

	// start point: add at (x+1, y+1), query corner picks high+1 or low edge
	always_comb begin
		if (is_add) begin
			si = IDX_W'(xl_q) + IDX_W'(1);
			sj = IDX_W'(yl_q) + IDX_W'(1);
		end else begin
			si = cmd.corner[0] ? IDX_W'(xl_q) : IDX_W'(xh_q) + IDX_W'(1);
			sj = cmd.corner[1] ? IDX_W'(yl_q) : IDX_W'(yh_q) + IDX_W'(1);
		end
	end

	assign j_nx = is_add ? j_q + low_bit(j_q) : j_q - low_bit(j_q);
	assign i_nx = is_add ? i_q + low_bit(i_q) : i_q - low_bit(i_q);

	assign row       = CW'(i_q - IDX_W'(1));
	assign col       = CW'(j_q - IDX_W'(1));
	assign cell_addr = {row, col};

	assign wr_en   = cmd.clr_en | cmd.add_wr;
	assign wr_addr = cmd.clr_en ? clr_addr_q : cell_addr;
	assign wr_data = cmd.clr_en ? '0 : mem_q + SUM_W'(weight_q);

	assign sts.clr_last = (clr_addr_q == '1);
	assign sts.is_query = (kind_q == KIND_QUERY);
	assign sts.empty    = (xl_q > xh_q) || (yl_q > yh_q);
	assign sts.cell_ok  = idx_ok(i_q, is_add) && idx_ok(j_q, is_add);

	assign range_sum = res_q;

	// tree memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		mem_q <= mem[cell_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cmd.clr_en)
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			xl_q     <= in_x_low;
			yl_q     <= in_y_low;
			xh_q     <= in_x_high;
			yh_q     <= in_y_high;
			weight_q <= in_weight;
		end
		if (cmd.start) begin
			i_q  <= si;
			j_q  <= sj;
			jb_q <= sj;
		end else if (cmd.advance) begin
			if (idx_ok(j_nx, is_add)) begin
				j_q <= j_nx;
			end else begin
				i_q <= i_nx;
				j_q <= jb_q;
			end
		end
		// mixed-sign corners subtract
		sub_s1 <= cmd.corner[0] ^ cmd.corner[1];
		if (cmd.load)
			acc_q <= '0;
		else if (rd_vld_s1)
			acc_q <= sub_s1 ? acc_q - mem_q : acc_q + mem_q;
		if (cmd.res_load)
			res_q <= acc_q;
	end

endmodule

// ----- hdl/rsp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_ctrl - sequencer of the rectangle sum block
// Clearing sweep, transaction decode, add read-modify-write loop,
// four-corner query read loop and result hand-off.
// ----------------------------------------------------------------------------
module rsp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	output logic             res_valid,
	input  logic             res_ready,
	output rsp_pkg::dp_cmd_t cmd,
	input  rsp_pkg::dp_sts_t sts
);
	import rsp_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_START,
		ST_Q_RD,
		ST_Q_DONE
	} state_t;

	state_t     state_q;
	logic       ready_q, res_valid_q;
	logic [1:0] corner_q;
	logic       accept;

	assign item_ready = ready_q;
	assign res_valid  = res_valid_q;
	assign accept     = item_valid && ready_q;

	always_comb begin
		cmd          = '0;
		cmd.corner   = corner_q;
		cmd.load     = accept;
		case (state_q)
			ST_CLEAR:   cmd.clr_en = 1'b1;
			ST_DECODE:  cmd.start  = 1'b1;
			ST_Q_START: cmd.start  = 1'b1;
			ST_ADD_WR: begin
				cmd.add_wr  = 1'b1;
				cmd.advance = 1'b1;
			end
			ST_Q_RD: begin
				cmd.rd_en   = sts.cell_ok;
				cmd.advance = sts.cell_ok;
			end
			ST_Q_DONE:  cmd.res_load = !res_valid_q || res_ready;
			default:    cmd.clr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ready_q     <= 1'b0;
			res_valid_q <= 1'b0;
			corner_q    <= CORNER_FIRST;
		end else begin
			// result register: filled from the query end, emptied by the sink
			if (state_q == ST_Q_DONE && (!res_valid_q || res_ready))
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ready_q  <= 1'b0;
						corner_q <= CORNER_FIRST;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (!sts.is_query)
						state_q <= ST_ADD_RD;
					else if (sts.empty)
						state_q <= ST_Q_DONE;
					else
						state_q <= ST_Q_RD;
				end
				ST_ADD_RD: begin
					if (sts.cell_ok) begin
						state_q <= ST_ADD_WR;
					end else begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_ADD_WR:  state_q <= ST_ADD_RD;
				ST_Q_START: state_q <= ST_Q_RD;
				ST_Q_RD: begin
					if (!sts.cell_ok) begin
						if (corner_q == CORNER_LAST) begin
							state_q <= ST_Q_DONE;
						end else begin
							corner_q <= corner_q + 2'd1;
							state_q  <= ST_Q_START;
						end
					end
				end
				ST_Q_DONE: begin
					if (!res_valid_q || res_ready) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// input only taken from idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> state_q == ST_IDLE)
		else $error("item ready outside idle");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!res_valid_q || res_ready))
		else $error("result register overwritten");

	// clearing sweep never overlaps tree traffic
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> (!cmd.add_wr && !cmd.rd_en && !ready_q))
		else $error("tree access during clear");

	// accepted transaction is decoded next cycle
	a_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DECODE)
		else $error("accepted transaction not decoded");

endmodule

// ----- hdl/rect_sum_point_update_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_sum_point_update_top - rectangle sum over a 64x64 grid, point updates
// Two-dimensional Fenwick store with a sequencer and a datapath.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-word tree memory to zero, one word a
// cycle, and item.ready first rises when the sweep is done. An add
// transaction (kind 0) adds weight at (x_low, y_low) and produces no result;
// it walks up to 7 x 7 = 49 tree cells (at the low grid edge), reading each
// cell and then writing it back. A query transaction (kind 1) returns the
// inclusive rectangle sum modulo 2^32 on the result channel; it reads up to
// 36 cells for each of four corner prefixes, one read per cycle, with a start
// state before each corner. An empty rectangle (low edge above high edge)
// returns 0. One transaction is worked at a time; a finished sum waits in an
// output register, so the next transaction is accepted while the result is
// still pending downstream.
// ----------------------------------------------------------------------------
module rect_sum_point_update_top (
	input  logic         clk,
	input  logic         arst_n,
	rsp_item_if.sink     item,
	rsp_result_if.source result
);
	import rsp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: owns all handshakes
	rsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// datapath: tree memory, index walk, accumulation
	rsp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (item.kind),
		.in_x_low  (item.x_low),
		.in_y_low  (item.y_low),
		.in_x_high (item.x_high),
		.in_y_high (item.y_high),
		.in_weight (item.weight),
		.range_sum (result.range_sum)
	);

endmodule

// ----- tb/rect_sum_point_update_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_sum_point_update_top_test - self-checking bench for the rectangle sum
// Feeds add and query transactions through the item channel. A 2-D Fenwick
// copy of the grid, kept in the bench, predicts each query sum. Sums arrive
// on the result channel and are checked in order. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module rect_sum_point_update_top_test;
	import rsp_pkg::*;

	localparam int EDGE        = GRID_SIZE - 1;
	localparam int RANDOM_OPS  = 1250;
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_WAIT    = 17;

	// one add or query as it goes onto the item channel
	typedef struct {
		logic    kind;
		coord_t  x_low;
		coord_t  y_low;
		coord_t  x_high;
		coord_t  y_high;
		weight_t weight;
		bit      drain_first;  // hold this one back until no sum is outstanding
	} grid_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsp_item_if   item_ch();
	rsp_result_if result_ch();

	rect_sum_point_update_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #2 clk = ~clk;

	grid_op_t pending_ops[$];  // stimulus not yet on the channel
	sum_t     sums_due[$];     // predicted sums, oldest first

	// Bench copy of the Fenwick store; cell (i, j) 1-based sits at (i-1)*GRID_SIZE + j-1.
	sum_t fen_cells [GRID_SIZE*GRID_SIZE] = '{default: '0};

	bit item_took = 1'b0;  // item transaction at the last rising edge
	bit sum_took  = 1'b0;  // result transaction at the last rising edge

	int send_gap   = 0;
	int recv_gap   = 0;
	int send_calm  = 0;
	int recv_calm  = 0;
	int error_count = 0;
	int n_adds = 0, n_queries = 0, n_empty = 0, n_checked = 0;
	int cycle_count = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		error_count++;
	endtask

	// Idle cycles before the next transaction on one side. Now and then a run
	// of transactions gets no idling at all.
	function automatic int draw_wait(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic fen_add(input int x, input int y, input sum_t w);
		for (int i = x + 1; i <= GRID_SIZE; i += i & -i)
			for (int j = y + 1; j <= GRID_SIZE; j += j & -j)
				fen_cells[(i-1)*GRID_SIZE + (j-1)] += w;
	endtask

	// sum of all points with x < nx and y < ny
	function automatic sum_t prefix_sum(input int nx, input int ny);
		sum_t acc;
		acc = '0;
		for (int i = nx; i > 0; i -= i & -i)
			for (int j = ny; j > 0; j -= j & -j)
				acc += fen_cells[(i-1)*GRID_SIZE + (j-1)];
		return acc;
	endfunction

	// inclusive rectangle by four corners; high edges clamp to the grid
	function automatic sum_t rect_sum(input grid_op_t op);
		int xl, yl, xh, yh;
		xl = int'(op.x_low);
		yl = int'(op.y_low);
		xh = (int'(op.x_high) > EDGE) ? EDGE : int'(op.x_high);
		yh = (int'(op.y_high) > EDGE) ? EDGE : int'(op.y_high);
		if (xl > EDGE || yl > EDGE || xl > xh || yl > yh)
			return '0;
		return prefix_sum(xh + 1, yh + 1) - prefix_sum(xl, yh + 1)
			- prefix_sum(xh + 1, yl) + prefix_sum(xl, yl);
	endfunction

	task automatic push_op(input logic kind, input int xl, input int yl, input int xh,
			input int yh, input int w, input bit drain);
		grid_op_t op;
		op.kind        = kind;
		op.x_low       = coord_t'(xl);
		op.y_low       = coord_t'(yl);
		op.x_high      = coord_t'(xh);
		op.y_high      = coord_t'(yh);
		op.weight      = weight_t'(w);
		op.drain_first = drain;
		pending_ops.push_back(op);
	endtask

	// ------------------------------------------------------------------------
	// Driver: everything changes on the falling edge. The flags from the
	// monitor tell which transactions completed at the rising edge before.
	// valid gets at most one assignment per edge, ready exactly one.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : driver
		grid_op_t nxt;
		if (arst_n) begin
			if (item_took)
				send_gap = draw_wait(send_calm);
			if (item_ch.valid && !item_took) begin
				// still waiting for ready, hold the transaction
			end else if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (pending_ops.size() != 0 &&
					(!pending_ops[0].drain_first || sums_due.size() == 0)) begin
				nxt = pending_ops.pop_front();
				item_ch.kind   <= nxt.kind;
				item_ch.x_low  <= nxt.x_low;
				item_ch.y_low  <= nxt.y_low;
				item_ch.x_high <= nxt.x_high;
				item_ch.y_high <= nxt.y_high;
				item_ch.weight <= nxt.weight;
				item_ch.valid  <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end

			// result side: after each sum, stall for a fresh random count
			if (sum_took)
				recv_gap = draw_wait(recv_calm);
			if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. Accepted items
	// update the bench grid (adds) or queue a predicted sum (queries).
	// Each result is matched against the oldest prediction. Items go first,
	// so the order of the two channels within an edge is fixed.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		grid_op_t seen;
		sum_t     want;
		item_took <= arst_n && item_ch.valid && item_ch.ready;
		sum_took  <= arst_n && result_ch.valid && result_ch.ready;

		if (arst_n && item_ch.valid && item_ch.ready) begin
			seen.kind        = item_ch.kind;
			seen.x_low       = item_ch.x_low;
			seen.y_low       = item_ch.y_low;
			seen.x_high      = item_ch.x_high;
			seen.y_high      = item_ch.y_high;
			seen.weight      = item_ch.weight;
			seen.drain_first = 1'b0;
			if (seen.kind == KIND_ADD) begin
				if (int'(seen.x_low) <= EDGE && int'(seen.y_low) <= EDGE)
					fen_add(int'(seen.x_low), int'(seen.y_low), sum_t'(seen.weight));
				n_adds++;
			end else begin
				sums_due.push_back(rect_sum(seen));
				n_queries++;
				if (seen.x_low > seen.x_high || seen.y_low > seen.y_high)
					n_empty++;
			end
		end

		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (sums_due.size() == 0) begin
				report_mismatch($sformatf("range_sum %0h with no query outstanding",
					result_ch.range_sum));
			end else begin
				want = sums_due.pop_front();
				n_checked++;
				if (result_ch.range_sum !== want)
					report_mismatch($sformatf("range_sum %0h, predicted %0h (result %0d)",
						result_ch.range_sum, want, n_checked));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d sums outstanding", cycle_count,
				sums_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int xa, xb, ya, yb, t, r, wv;
		int last_x, last_y;

		item_ch.valid   = 1'b0;
		item_ch.kind    = KIND_ADD;
		item_ch.x_low   = '0;
		item_ch.y_low   = '0;
		item_ch.x_high  = '0;
		item_ch.y_high  = '0;
		item_ch.weight  = '0;
		result_ch.ready = 1'b0;

		// Directed part. A query on the empty grid, then adds at the four
		// corners, a zero weight and a repeated max weight. Some adds carry
		// nonzero high edges, which the block must ignore. Then single cells,
		// full rows and columns, the full grid, two quadrants, an inner
		// rectangle and both kinds of inverted rectangle.
		push_op(KIND_QUERY, 0, 0, EDGE, EDGE, 16'hFFFF, 1'b0);
		push_op(KIND_ADD, 0, 0, EDGE, EDGE, 16'hFFFF, 1'b0);
		push_op(KIND_ADD, EDGE, EDGE, 0, 0, 16'hFFFF, 1'b0);
		push_op(KIND_ADD, 0, EDGE, EDGE, 0, 1, 1'b0);
		push_op(KIND_ADD, EDGE, 0, 0, EDGE, 16'h8000, 1'b0);
		push_op(KIND_ADD, 5, 9, 0, 0, 0, 1'b0);
		push_op(KIND_ADD, 31, 32, 42, 21, 16'hAAAA, 1'b0);
		push_op(KIND_ADD, 32, 31, 21, 42, 16'h5555, 1'b0);
		repeat (3)
			push_op(KIND_ADD, 17, 40, 0, 0, 16'hFFFF, 1'b0);
		push_op(KIND_QUERY, 0, 0, EDGE, EDGE, 0, 1'b0);
		push_op(KIND_QUERY, 0, 0, 0, 0, 0, 1'b0);
		push_op(KIND_QUERY, EDGE, EDGE, EDGE, EDGE, 0, 1'b0);
		push_op(KIND_QUERY, 10, 0, 9, EDGE, 0, 1'b0);        // low x above high x
		push_op(KIND_QUERY, 0, 40, EDGE, 39, 0, 1'b0);       // low y above high y
		push_op(KIND_QUERY, EDGE, 0, EDGE, EDGE, 0, 1'b0);
		push_op(KIND_QUERY, 1, 1, EDGE - 1, EDGE - 1, 0, 1'b0);
		push_op(KIND_QUERY, 0, 0, EDGE, 0, 0, 1'b0);
		push_op(KIND_QUERY, 0, EDGE, EDGE, EDGE, 0, 1'b0);
		push_op(KIND_QUERY, 31, 32, 31, 32, 0, 1'b0);
		push_op(KIND_QUERY, 17, 40, 17, 40, 0, 1'b0);
		push_op(KIND_QUERY, 0, 0, 31, 31, 0, 1'b0);
		push_op(KIND_QUERY, 32, 32, EDGE, EDGE, 16'h5555, 1'b0);

		// Random part: a bit under half adds. Queries are mostly random
		// rectangles, some tight windows around the last add point, and a
		// few inverted ones. Every 300th transaction waits for all sums to
		// drain first.
		last_x = 0;
		last_y = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			r = $urandom_range(0, 19);
			if ($urandom_range(0, 99) < 45) begin
				xa = $urandom_range(0, EDGE);
				ya = $urandom_range(0, EDGE);
				wv = (r == 0) ? 16'hFFFF : (r == 1) ? 0 : $urandom_range(0, 16'hFFFF);
				push_op(KIND_ADD, xa, ya, $urandom_range(0, EDGE), $urandom_range(0, EDGE),
					wv, n % 300 == 0);
				last_x = xa;
				last_y = ya;
			end else begin
				xa = $urandom_range(0, EDGE);
				xb = $urandom_range(0, EDGE);
				ya = $urandom_range(0, EDGE);
				yb = $urandom_range(0, EDGE);
				if (xa > xb) begin
					t = xa; xa = xb; xb = t;
				end
				if (ya > yb) begin
					t = ya; ya = yb; yb = t;
				end
				if (r < 2) begin
					// inverted on one axis: low edge strictly above high edge
					if (r == 0) begin
						xa = $urandom_range(1, EDGE);
						xb = $urandom_range(0, xa - 1);
					end else begin
						ya = $urandom_range(1, EDGE);
						yb = $urandom_range(0, ya - 1);
					end
				end else if (r < 6) begin
					xa = last_x - $urandom_range(0, 2);
					xb = last_x + $urandom_range(0, 2);
					ya = last_y - $urandom_range(0, 2);
					yb = last_y + $urandom_range(0, 2);
					if (xa < 0) xa = 0;
					if (ya < 0) ya = 0;
					if (xb > EDGE) xb = EDGE;
					if (yb > EDGE) yb = EDGE;
				end
				push_op(KIND_QUERY, xa, ya, xb, yb, $urandom_range(0, 16'hFFFF), n % 300 == 0);
			end
		end

		// hold reset, release it on a falling edge; the block then clears its store on its own
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (sums_due.size() != 0)
			@(posedge clk);
		// let a late or stray result show up
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d adds and %0d queries (%0d with empty rectangles), %0d sums checked",
			n_adds, n_queries, n_empty, n_checked);
		$display("Both channels stalled at random, with quiet stretches and drain pauses");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/rsp_pkg.sv
hdl/rsp_if.sv
hdl/rsp_datapath.sv
hdl/rsp_ctrl.sv
hdl/rect_sum_point_update_top.sv
tb/rect_sum_point_update_top_test.sv
